// ===== rtl/fkvt_pkg.sv =====
// ----------------------------------------------------------------------------
// fkvt_pkg
// Types and codes shared by the feature key/value table and its channels.
// ----------------------------------------------------------------------------
package fkvt_pkg;

    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_FEATURE = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] creator;
        logic [15:0] feature_number;
        logic [31:0] new_value;
        logic        is_pointer;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic        found_pointer;
    } rsp_t;

    // One table entry as it sits in the memory.
    typedef struct packed {
        logic [31:0] creator;
        logic [15:0] feature;
        logic [31:0] value;
        logic        pointer_flag;
    } entry_t;

endpackage

// ===== rtl/fkvt_if.sv =====
// ----------------------------------------------------------------------------
// fkvt request and response channels
// Valid/ready channels that carry one request item or one result item.
// ----------------------------------------------------------------------------
interface fkvt_req_if;
    import fkvt_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fkvt_rsp_if;
    import fkvt_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/fkvt_mem.sv =====
// ----------------------------------------------------------------------------
// fkvt_mem
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fkvt_mem #(
    parameter int TABLE_DEPTH = 32,
    parameter int IDX_W       = 5
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output fkvt_pkg::entry_t      rd_data,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  fkvt_pkg::entry_t      wr_data
);
    import fkvt_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/fkvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// fkvt_ctrl
// Sequencer: scans the live entries, applies get, set or remove, and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module fkvt_ctrl #(
    parameter int TABLE_DEPTH = 32,
    parameter int IDX_W       = 5,
    parameter int CNT_W       = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    fkvt_req_if.sink              req,
    fkvt_rsp_if.source            rsp,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    input  fkvt_pkg::entry_t      rd_data,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output fkvt_pkg::entry_t      wr_data
);
    import fkvt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_COPY,
        S_RESP
    } state_t;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    state_t           state_reg, state_next;
    req_t             item_reg, item_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic [CNT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             hit_reg, hit_next;
    logic [CNT_W-1:0] slot_reg, slot_next;
    entry_t           hit_entry_reg, hit_entry_next;
    rsp_t             res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg, out_next;

    logic             key_match;
    logic [CNT_W-1:0] last_idx;

    assign key_match = (rd_data.creator == item_reg.creator)
                    && (rd_data.feature == item_reg.feature_number);
    assign last_idx  = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = 1'b0;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        hit_entry_next = hit_entry_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = slot_reg[IDX_W-1:0];
        wr_data        = '{creator: item_reg.creator, feature: item_reg.feature_number,
                           value: item_reg.new_value, pointer_flag: item_reg.is_pointer};

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    item_next  = req.payload;
                    issue_next = '0;
                    hit_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Reads go out one per cycle; each compare sees the data of the
                // read issued the cycle before.
                if (cmp_valid_reg && key_match)
                begin
                    hit_next       = 1'b1;
                    slot_next      = cmp_idx_reg;
                    hit_entry_next = rd_data;
                    state_next     = S_ACT;
                end
                else if (issue_reg == count_reg)
                begin
                    hit_next   = 1'b0;
                    state_next = S_ACT;
                end
                else
                begin
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg;
                    issue_next     = issue_reg + CNT_W'(1);
                end
            end

            S_ACT:
            begin
                res_next   = '{status: ST_NO_FEATURE, found_value: '0, found_pointer: 1'b0};
                state_next = S_RESP;
                case (item_reg.op)
                    OP_GET:
                    begin
                        if (hit_reg)
                        begin
                            res_next = '{status: ST_OK, found_value: hit_entry_reg.value,
                                         found_pointer: hit_entry_reg.pointer_flag};
                        end
                    end
                    OP_SET:
                    begin
                        if (hit_reg)
                        begin
                            wr_en           = 1'b1;
                            res_next.status = ST_OK;
                        end
                        else if (count_reg < DEPTH_CNT)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = count_reg[IDX_W-1:0];
                            count_next      = count_reg + CNT_W'(1);
                            res_next.status = ST_OK;
                        end
                        else
                        begin
                            res_next.status = ST_FULL;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            count_next      = last_idx;
                            res_next.status = ST_OK;
                            // The last live entry moves into the freed slot.
                            if (slot_reg < last_idx)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = last_idx[IDX_W-1:0];
                                state_next = S_COPY;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_COPY:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            hit_reg       <= 1'b0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            item_reg      <= '0;
            hit_entry_reg <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            hit_reg       <= hit_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            item_reg      <= item_next;
            hit_entry_reg <= hit_entry_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
        end
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule

// ===== rtl/feature_key_value_table.sv =====
// ----------------------------------------------------------------------------
// feature_key_value_table
// Associative table of feature values keyed by creator code and feature number.
// ----------------------------------------------------------------------------
// The table takes one request item at a time and returns exactly one result
// item for it. Each request scans the live entries in slot order through the
// entry memory, one read per cycle. A hit ends the scan early, and a remove
// that moves the last entry adds a copy step before the result is staged.
// A finished result waits in an output register, and the next request is
// taken as soon as that result is staged.
// The memory needs no clearing after reset: only slots below the live count
// are ever read.
module feature_key_value_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    fkvt_req_if.sink    req,
    fkvt_rsp_if.source  rsp
);
    import fkvt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    fkvt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    fkvt_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

// ===== rtl/fkvt_checker.sv =====
// ----------------------------------------------------------------------------
// fkvt_checker
// Port-level checks on the feature key/value table, bound to its top level.
// ----------------------------------------------------------------------------
module fkvt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [31:0] rsp_found_value,
    input logic        rsp_found_pointer
);
    import fkvt_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_found_value) && $stable(rsp_found_pointer))
    else $error("stalled result changed");

    // Only a successful lookup carries a value or a pointer flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_found_value == 32'd0 && !rsp_found_pointer)
    else $error("failed request returned data");

    // One request is in work at a time: the table is busy right after taking one.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");

    // A newly accepted request cannot produce a result in the following cycle, as
    // the scan lies between acceptance and the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid |=> !rsp_valid)
    else $error("result appeared without a scan");

endmodule

bind feature_key_value_table fkvt_checker u_fkvt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.payload.status),
    .rsp_found_value   (rsp.payload.found_value),
    .rsp_found_pointer (rsp.payload.found_pointer)
);

// ===== dv/feature_key_value_table_tb.sv =====
// ----------------------------------------------------------------------------
// feature_key_value_table_tb
// Drives get, set and remove requests into the feature table and checks every
// result against a shadow copy of the table kept inside the testbench.
// ----------------------------------------------------------------------------
// A directed pass covers the key extremes, each operation, misses, updates,
// removal from the front and from the end, and the unused op code. A fill
// pass takes the table to full and probes it there. Random traffic then
// swings the occupancy up and down over a small key pool. A later pass holds
// the result channel off for a long stretch so that the block backs up.
module feature_key_value_table_tb;
    import fkvt_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_POOL = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 50;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} stall_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    fkvt_req_if req_if ();
    fkvt_rsp_if rsp_if ();

    feature_key_value_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_if),
        .rsp(rsp_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the table.
    logic [31:0] shadow_creator [TABLE_DEPTH];
    logic [15:0] shadow_feature [TABLE_DEPTH];
    logic [31:0] shadow_value [TABLE_DEPTH];
    logic        shadow_pointer [TABLE_DEPTH];
    int          live_entries = 0;

    logic [31:0] pool_creator [KEY_POOL];
    logic [15:0] pool_feature [KEY_POOL];

    rsp_t pending_feature_results [$];

    int error_count = 0;
    int op_seen [4] = '{default: 0};
    int status_seen [4] = '{default: 0};
    int peak_live = 0;
    int burst_left = 1;
    bit sender_gaps_on = 1'b1;
    bit hold_results = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic req_t make_request(input logic [1:0] op, input logic [31:0] creator,
                                          input logic [15:0] feature, input logic [31:0] value,
                                          input logic ptr);
        req_t item;
        item.op = op;
        item.creator = creator;
        item.feature_number = feature;
        item.new_value = value;
        item.is_pointer = ptr;
        return item;
    endfunction

    // Applies one request to the shadow table and returns the result it causes.
    function automatic rsp_t apply_feature_request(input req_t item);
        rsp_t res;
        int   slot;
        int   last;
        int   k;
        res.status = ST_NO_FEATURE;
        res.found_value = '0;
        res.found_pointer = 1'b0;
        slot = -1;
        for (k = 0; k < live_entries; k++)
        begin
            if (slot < 0 && shadow_creator[k] == item.creator
                    && shadow_feature[k] == item.feature_number)
                slot = k;
        end
        op_seen[item.op]++;
        case (item.op)
            OP_GET:
            begin
                if (slot >= 0)
                begin
                    res.status = ST_OK;
                    res.found_value = shadow_value[slot];
                    res.found_pointer = shadow_pointer[slot];
                end
            end
            OP_SET:
            begin
                if (slot < 0 && live_entries < TABLE_DEPTH)
                begin
                    slot = live_entries;
                    shadow_creator[slot] = item.creator;
                    shadow_feature[slot] = item.feature_number;
                    live_entries++;
                end
                if (slot >= 0)
                begin
                    shadow_value[slot] = item.new_value;
                    shadow_pointer[slot] = item.is_pointer;
                    res.status = ST_OK;
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
            OP_REMOVE:
            begin
                if (slot >= 0)
                begin
                    last = live_entries - 1;
                    if (slot < last)
                    begin
                        shadow_creator[slot] = shadow_creator[last];
                        shadow_feature[slot] = shadow_feature[last];
                        shadow_value[slot] = shadow_value[last];
                        shadow_pointer[slot] = shadow_pointer[last];
                    end
                    live_entries = last;
                    res.status = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
        status_seen[res.status]++;
        if (live_entries > peak_live)
            peak_live = live_entries;
        return res;
    endfunction

    // Called just after a rising edge. Returns once the item is accepted, or
    // after the idle gap that closes a burst.
    task automatic offer_request(input req_t item);
        req_if.valid <= 1'b1;
        req_if.payload <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_feature_results.push_back(apply_feature_request(item));
        if (sender_gaps_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 10);
            end
        end
    endtask

    task automatic test_directed_cases();
        logic [31:0] c2;
        c2 = 32'h8000_0001;
        offer_request(make_request(OP_GET, 32'h0, 16'h0, 32'h0, 1'b0));
        offer_request(make_request(OP_REMOVE, 32'h0, 16'h0, 32'h0, 1'b0));
        offer_request(make_request(OP_UNUSED, 32'h0, 16'h0, 32'h0, 1'b0));
        offer_request(make_request(OP_SET, 32'h0, 16'h0, 32'h0, 1'b0));
        offer_request(make_request(OP_SET, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        offer_request(make_request(OP_SET, c2, 16'h1234, 32'h5A5A_A5A5, 1'b1));
        offer_request(make_request(OP_GET, 32'h0, 16'h0, 32'hFFFF_FFFF, 1'b1));
        offer_request(make_request(OP_GET, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 1'b0));
        // Keys that share one half with a stored key must miss.
        offer_request(make_request(OP_GET, 32'h0, 16'hFFFF, 32'h0, 1'b0));
        offer_request(make_request(OP_GET, 32'hFFFF_FFFF, 16'h0, 32'h0, 1'b0));
        offer_request(make_request(OP_SET, 32'h0, 16'h0, 32'hFFFF_FFFF, 1'b1));
        offer_request(make_request(OP_GET, 32'h0, 16'h0, 32'h0, 1'b0));
        // Removing slot zero moves the last entry down into it.
        offer_request(make_request(OP_REMOVE, 32'h0, 16'h0, 32'h1, 1'b1));
        offer_request(make_request(OP_GET, c2, 16'h1234, 32'h0, 1'b0));
        offer_request(make_request(OP_GET, 32'h0, 16'h0, 32'h0, 1'b0));
        offer_request(make_request(OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 1'b0));
        offer_request(make_request(OP_GET, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 1'b0));
        offer_request(make_request(OP_UNUSED, c2, 16'h1234, 32'hFFFF_FFFF, 1'b1));
        offer_request(make_request(OP_GET, c2, 16'h1234, 32'h0, 1'b0));
        offer_request(make_request(OP_REMOVE, c2, 16'h1234, 32'h0, 1'b0));
        offer_request(make_request(OP_REMOVE, c2, 16'h1234, 32'h0, 1'b0));
    endtask

    task automatic test_table_full();
        int          idx;
        logic [31:0] c;
        logic [15:0] f;
        while (live_entries < TABLE_DEPTH)
            offer_request(make_request(OP_SET, $urandom, 16'($urandom), $urandom,
                                       1'($urandom)));
        repeat (2)
            offer_request(make_request(OP_SET, $urandom, 16'($urandom), $urandom,
                                       1'($urandom)));
        // An update still succeeds while the table is full.
        idx = $urandom_range(0, TABLE_DEPTH - 1);
        c = shadow_creator[idx];
        f = shadow_feature[idx];
        offer_request(make_request(OP_SET, c, f, $urandom, 1'($urandom)));
        offer_request(make_request(OP_GET, c, f, $urandom, 1'($urandom)));
        idx = $urandom_range(0, TABLE_DEPTH - 2);
        offer_request(make_request(OP_REMOVE, shadow_creator[idx], shadow_feature[idx],
                                   $urandom, 1'($urandom)));
        offer_request(make_request(OP_GET, shadow_creator[idx], shadow_feature[idx],
                                   $urandom, 1'($urandom)));
        c = $urandom;
        f = 16'($urandom);
        offer_request(make_request(OP_SET, c, f, $urandom, 1'($urandom)));
        offer_request(make_request(OP_GET, c, f, $urandom, 1'($urandom)));
    endtask

    function automatic req_t random_request(input bit growing);
        int          pick;
        int          idx;
        logic [1:0]  op;
        logic [31:0] c;
        logic [15:0] f;
        pick = $urandom_range(0, 99);
        if (growing)
            op = (pick < 50) ? OP_SET : (pick < 75) ? OP_GET : (pick < 97) ? OP_REMOVE : OP_UNUSED;
        else
            op = (pick < 15) ? OP_SET : (pick < 45) ? OP_GET : (pick < 97) ? OP_REMOVE : OP_UNUSED;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            c = $urandom;
            f = 16'($urandom);
        end
        else if (pick < 5 && live_entries > 0)
        begin
            idx = $urandom_range(0, live_entries - 1);
            c = shadow_creator[idx];
            f = shadow_feature[idx];
        end
        else
        begin
            idx = $urandom_range(0, KEY_POOL - 1);
            c = pool_creator[idx];
            f = pool_feature[idx];
        end
        return make_request(op, c, f, $urandom, 1'($urandom));
    endfunction

    // Occupancy swings between shrinking and growing phases of 50 items each.
    task automatic test_random_traffic(input int n_items);
        int i;
        for (i = 0; i < n_items; i++)
            offer_request(random_request(((i / 50) % 2) == 1));
    endtask

    task automatic test_backpressure();
        int i;
        sender_gaps_on = 1'b0;
        hold_results = 1'b1;
        for (i = 0; i < 20; i++)
            offer_request(random_request(i % 2 == 0));
        while (hold_results)
            @(posedge clk);
        sender_gaps_on = 1'b1;
    endtask

    // Pool keys come in pairs that share one half of the key.
    initial
    begin : key_pool_setup
        int i;
        for (i = 0; i < KEY_POOL; i++)
        begin
            if (i % 2 == 1)
            begin
                pool_creator[i] = (i % 4 == 1) ? pool_creator[i - 1] : pool_creator[i - 1] ^ 32'h1;
                pool_feature[i] = (i % 4 == 1) ? ~pool_feature[i - 1] : pool_feature[i - 1];
            end
            else
            begin
                pool_creator[i] = $urandom;
                pool_feature[i] = 16'($urandom);
            end
        end
    end

    initial
    begin : result_receiver
        int          hold_count;
        int          pattern_left;
        int          phase_count;
        stall_mode_t pattern_mode;
        hold_count = 0;
        pattern_left = 0;
        phase_count = 0;
        pattern_mode = RX_ALWAYS;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                rsp_if.ready <= 1'b0;
                hold_count++;
                if (hold_count == HOLD_CYCLES)
                begin
                    hold_count = 0;
                    hold_results = 1'b0;
                end
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_mode = stall_mode_t'($urandom_range(0, 2));
                    pattern_left = $urandom_range(20, 120);
                end
                pattern_left--;
                phase_count++;
                case (pattern_mode)
                    RX_ALWAYS:   rsp_if.ready <= 1'b1;
                    RX_RANDOM:   rsp_if.ready <= 1'($urandom);
                    RX_PERIODIC: rsp_if.ready <= (phase_count % 4 == 0);
                    default:     rsp_if.ready <= 1'b1;
                endcase
            end
        end
    end

    initial
    begin : result_checker
        rsp_t got;
        rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.payload;
                if (pending_feature_results.size() == 0)
                begin
                    report_mismatch("result with no request pending", got.found_value, '0);
                end
                else
                begin
                    want = pending_feature_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.found_value !== want.found_value)
                        report_mismatch("found_value", got.found_value, want.found_value);
                    if (got.found_pointer !== want.found_pointer)
                        report_mismatch("found_pointer", 32'(got.found_pointer),
                                        32'(want.found_pointer));
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_feature_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : test_sequence
        req_if.valid <= 1'b0;
        req_if.payload <= '0;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_table_full();
        test_random_traffic(300);
        test_backpressure();
        test_random_traffic(40);
        req_if.valid <= 1'b0;
        while (pending_feature_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d requests: %0d get, %0d set, %0d remove, %0d with the unused op code.",
                 op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
                 op_seen[OP_GET], op_seen[OP_SET], op_seen[OP_REMOVE], op_seen[OP_UNUSED]);
        $display("Results: %0d ok, %0d missing key, %0d table full; peak occupancy %0d of %0d.",
                 status_seen[ST_OK], status_seen[ST_NO_FEATURE], status_seen[ST_FULL],
                 peak_live, TABLE_DEPTH);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
